// ----- src/cfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared types, constants and the CRC-16 byte update of the frame encoder.
// ----------------------------------------------------------------------------
package cfe_pkg;

    localparam int unsigned MAX_RESULTS = 6;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // Header bytes plus CRC bytes around the payload
    localparam logic [8:0]  HDR_PLUS_CRC = 9'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

    localparam logic [7:0] MAGIC_RST   = 8'h00;
    localparam logic [7:0] VERSION_RST = 8'h00;
    localparam logic [7:0] MAX_LEN_RST = 8'hFF;

    localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_DATA   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_DATA_E = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_HDR    = CNT_W'(4);
    localparam logic [CNT_W-1:0] CNT_HDR_E  = CNT_W'(MAX_RESULTS);

    // One group of results produced by a single input item
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            cnt;
        logic                        frame_end;
        logic                        rejected;
    } cfe_burst_t;

    // CRC-16/CCITT, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- src/cfe_item_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_item_if
// Input request channel: start items and payload bytes.
// ----------------------------------------------------------------------------
interface cfe_item_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] opcode;
    logic [7:0] payload_length;
    logic [8:0] capacity;
    logic [7:0] data_byte;

    modport source (output valid, mode, opcode, payload_length, capacity, data_byte,
                    input ready);
    modport sink   (input valid, mode, opcode, payload_length, capacity, data_byte,
                    output ready);
endinterface

// ----- src/cfe_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_result_if
// Output request channel: one encoded byte or a reject marker.
// ----------------------------------------------------------------------------
interface cfe_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       rejected;

    modport source (output valid, out_byte, frame_end, rejected, input ready);
    modport sink   (input valid, out_byte, frame_end, rejected, output ready);
endinterface

// ----- src/cfe_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface cfe_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cfe_pkg::CFG_IDX_W-1:0]   index;
    logic [7:0]                      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/cfe_burst_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_burst_buf
// Holds the results of one item and drains them one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module cfe_burst_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  cfe_pkg::cfe_burst_t burst,
    output logic                free,
    cfe_result_if.source        result
);

    logic [cfe_pkg::MAX_RESULTS-1:0][7:0] byte_reg, byte_next;
    logic [cfe_pkg::CNT_W-1:0]            cnt_reg, cnt_next;
    logic                                 end_reg, end_next;
    logic                                 rej_reg, rej_next;
    logic                                 take;

    assign take             = result.valid && result.ready;
    assign free             = (cnt_reg == '0) || ((cnt_reg == cfe_pkg::CNT_ONE) && result.ready);
    assign result.valid     = (cnt_reg != '0);
    assign result.out_byte  = byte_reg[0];
    assign result.frame_end = end_reg && (cnt_reg == cfe_pkg::CNT_ONE);
    assign result.rejected  = rej_reg;

    always_comb
    begin
        byte_next = byte_reg;
        cnt_next  = cnt_reg;
        end_next  = end_reg;
        rej_next  = rej_reg;
        if (load)
        begin
            byte_next = burst.bytes;
            cnt_next  = burst.cnt;
            end_next  = burst.frame_end;
            rej_next  = burst.rejected;
        end
        else if (take)
        begin
            // advance to the next queued byte
            for (int i = 0; i < cfe_pkg::MAX_RESULTS - 1; i++)
            begin
                byte_next[i] = byte_reg[i+1];
            end
            cnt_next = cnt_reg - cfe_pkg::CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            end_reg <= 1'b0;
            rej_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            end_reg <= end_next;
            rej_reg <= rej_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

// ----- src/crc16_frame_encoder.sv -----
`timescale 1ns / 1ps
// Flow: an accepted item is registered in the input register; its results load into the
//   output buffer once the buffer is free, and the buffer then offers the first result.
// Throughput: one item per cycle while each item yields at most one result and the output is
//   ready; a start yields 4 or 6 results (1 for a reject), the end of a frame 3, and input stalls while they drain.
// Reset: frame state and buffers cleared, registers return to magic 0, version 0,
//   maximum payload 255.
// ----------------------------------------------------------------------------
// crc16_frame_encoder
// Framed packet encoder: header, payload pass-through and CRC-16 trailer.
// ----------------------------------------------------------------------------
module crc16_frame_encoder (
    input  logic          clk,
    input  logic          rst_n,
    cfe_item_if.sink      item,
    cfe_result_if.source  result,
    cfe_cfg_if.sink       cfg
);

    // configuration registers
    logic [7:0]  magic_reg, magic_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  max_len_reg, max_len_next;
    logic [15:0] crc_mv_reg;

    // input register
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_mode_reg;
    logic [7:0]  s1_opcode_reg;
    logic [7:0]  s1_len_reg;
    logic [8:0]  s1_cap_reg;
    logic [7:0]  s1_data_reg;

    // frame state
    logic        in_frame_reg, in_frame_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] crc_reg, crc_next;

    logic                 item_take;
    logic                 load;
    logic                 buf_free;
    logic                 reject;
    logic [15:0]          crc_op;
    logic [15:0]          crc_hdr;
    logic [15:0]          crc_dat;
    cfe_pkg::cfe_burst_t  burst;

    assign cfg.ready  = 1'b1;
    assign item.ready = !s1_valid_reg || buf_free;
    assign item_take  = item.valid && item.ready;
    assign load       = s1_valid_reg && buf_free;

    // ---------------- configuration ----------------
    always_comb
    begin
        magic_next   = magic_reg;
        version_next = version_reg;
        max_len_next = max_len_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                cfe_pkg::CFG_MAGIC:   magic_next   = cfg.data;
                cfe_pkg::CFG_VERSION: version_next = cfg.data;
                cfe_pkg::CFG_MAX_LEN: max_len_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= cfe_pkg::MAGIC_RST;
            version_reg <= cfe_pkg::VERSION_RST;
            max_len_reg <= cfe_pkg::MAX_LEN_RST;
            crc_mv_reg  <= cfe_pkg::crc_byte(cfe_pkg::crc_byte(cfe_pkg::CRC_INIT,
                                             cfe_pkg::MAGIC_RST), cfe_pkg::VERSION_RST);
        end
        else
        begin
            magic_reg   <= magic_next;
            version_reg <= version_next;
            max_len_reg <= max_len_next;
            // CRC over magic and version, updated together with the registers
            crc_mv_reg  <= cfe_pkg::crc_byte(cfe_pkg::crc_byte(cfe_pkg::CRC_INIT,
                                             magic_next), version_next);
        end
    end

    // ---------------- input register ----------------
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_take)
            s1_valid_next = 1'b1;
        else if (load)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_mode_reg   <= item.mode;
            s1_opcode_reg <= item.opcode;
            s1_len_reg    <= item.payload_length;
            s1_cap_reg    <= item.capacity;
            s1_data_reg   <= item.data_byte;
        end
    end

    // ---------------- frame logic ----------------
    assign reject  = (s1_len_reg > max_len_reg) ||
                     (({1'b0, s1_len_reg} + cfe_pkg::HDR_PLUS_CRC) > s1_cap_reg);
    assign crc_op  = cfe_pkg::crc_byte(crc_mv_reg, s1_opcode_reg);
    assign crc_hdr = cfe_pkg::crc_byte(crc_op, s1_len_reg);
    assign crc_dat = cfe_pkg::crc_byte(crc_reg, s1_data_reg);

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        crc_next        = crc_reg;
        burst           = '0;
        if (load)
        begin
            if (!s1_mode_reg)
            begin
                // a start abandons any open frame
                in_frame_next   = 1'b0;
                bytes_left_next = '0;
                crc_next        = cfe_pkg::CRC_INIT;
                if (reject)
                begin
                    burst.cnt       = cfe_pkg::CNT_ONE;
                    burst.frame_end = 1'b1;
                    burst.rejected  = 1'b1;
                end
                else
                begin
                    burst.bytes[0] = magic_reg;
                    burst.bytes[1] = version_reg;
                    burst.bytes[2] = s1_opcode_reg;
                    burst.bytes[3] = s1_len_reg;
                    if (s1_len_reg == '0)
                    begin
                        burst.bytes[4]  = crc_hdr[15:8];
                        burst.bytes[5]  = crc_hdr[7:0];
                        burst.cnt       = cfe_pkg::CNT_HDR_E;
                        burst.frame_end = 1'b1;
                    end
                    else
                    begin
                        burst.cnt       = cfe_pkg::CNT_HDR;
                        in_frame_next   = 1'b1;
                        bytes_left_next = s1_len_reg;
                        crc_next        = crc_hdr;
                    end
                end
            end
            else if (in_frame_reg)
            begin
                burst.bytes[0] = s1_data_reg;
                if (bytes_left_reg == 8'd1)
                begin
                    burst.bytes[1]  = crc_dat[15:8];
                    burst.bytes[2]  = crc_dat[7:0];
                    burst.cnt       = cfe_pkg::CNT_DATA_E;
                    burst.frame_end = 1'b1;
                    in_frame_next   = 1'b0;
                    bytes_left_next = '0;
                    crc_next        = crc_dat;
                end
                else
                begin
                    burst.cnt       = cfe_pkg::CNT_DATA;
                    bytes_left_next = bytes_left_reg - 8'd1;
                    crc_next        = crc_dat;
                end
            end
            // drop payload bytes that arrive outside a frame
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= '0;
            crc_reg        <= cfe_pkg::CRC_INIT;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            crc_reg        <= crc_next;
        end
    end

    cfe_burst_buf u_burst_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .burst  (burst),
        .free   (buf_free),
        .result (result)
    );

    // ---------------- assertions ----------------
    a_reject_ends : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.rejected |-> result.frame_end)
        else $error("reject result without frame_end");

    a_open_frame_count : assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (bytes_left_reg != 8'd0))
        else $error("open frame with no bytes left");

    a_hold_input : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !load |=> s1_valid_reg && $stable(s1_mode_reg) &&
        $stable(s1_len_reg))
        else $error("input register lost a pending item");

    a_load_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        load && result.valid |-> result.ready && !(result.valid && !result.frame_end &&
        result.rejected))
        else $error("results loaded over undelivered bytes");

endmodule

// ----- verif/crc16_frame_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_frame_encoder_tb
// Self-checking bench for the framed packet encoder. A queue of start and
// payload requests feeds a clocked driver; every accepted request goes through
// a local frame/CRC-16 predictor, and a clocked monitor compares each output
// byte with the oldest predicted one. Directed corner cases run first, then
// random frames (well-formed, rejected, cut short, stray bytes) under several
// register settings, with random idling and one long output hold-off.
// ----------------------------------------------------------------------------
module crc16_frame_encoder_tb;

    localparam int          CLK_HALF     = 4;
    localparam int          LIMIT_CYCLES = 200000;
    localparam int          SETTLE       = 16;
    localparam int          IDLE_PCT     = 10;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          MAX_REPORTS  = 10;
    localparam logic        MODE_START   = 1'b0;
    localparam logic        MODE_DATA    = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] opcode;
        logic [7:0] payload_length;
        logic [8:0] capacity;
        logic [7:0] data_byte;
    } frame_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       rejected;
    } frame_byte_t;

    logic clk;
    logic rst_n;

    cfe_item_if   item_ch ();
    cfe_result_if res_ch ();
    cfe_cfg_if    cfg_ch ();

    crc16_frame_encoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Pending requests and predicted output bytes
    frame_req_t  pending_reqs[$];
    frame_byte_t want_bytes[$];

    // Local copy of the registers and the frame state
    logic [7:0]  cfg_magic;
    logic [7:0]  cfg_version;
    logic [7:0]  cfg_max;
    logic        frame_open;
    logic [7:0]  bytes_left;
    logic [15:0] crc_acc;

    int n_queued;
    int n_accepted;
    int n_checked;
    int n_mismatch;
    int n_frames;
    int n_rejects;
    int n_abandoned;
    int n_stray;
    int n_settings;
    int cycle_cnt;

    logic no_idle;
    logic hold_req;
    logic rx_hold;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d bytes still awaited",
                     cycle_cnt, want_bytes.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // CRC-16/CCITT fed one bit at a time, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0};
            if (fb)
                crc = crc ^ cfe_pkg::CRC_POLY;
        end
        return crc;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic fend, input logic rej);
        frame_byte_t w;
        w.out_byte  = b;
        w.frame_end = fend;
        w.rejected  = rej;
        want_bytes.push_back(w);
    endfunction

    function automatic void emit_frame_byte(input logic [7:0] b);
        crc_acc = crc16_step(crc_acc, b);
        push_byte(b, 1'b0, 1'b0);
    endfunction

    function automatic void close_frame();
        push_byte(crc_acc[15:8], 1'b0, 1'b0);
        push_byte(crc_acc[7:0], 1'b1, 1'b0);
        frame_open = 1'b0;
        bytes_left = 8'd0;
        n_frames++;
    endfunction

    function automatic void predict_frame(input frame_req_t r);
        if (r.mode == MODE_START)
        begin
            if (frame_open)
                n_abandoned++;
            frame_open = 1'b0;
            bytes_left = 8'd0;
            crc_acc    = cfe_pkg::CRC_INIT;
            if (r.payload_length > cfg_max ||
                {1'b0, r.payload_length} + cfe_pkg::HDR_PLUS_CRC > r.capacity)
            begin
                push_byte(8'h00, 1'b1, 1'b1);
                n_rejects++;
            end
            else
            begin
                emit_frame_byte(cfg_magic);
                emit_frame_byte(cfg_version);
                emit_frame_byte(r.opcode);
                emit_frame_byte(r.payload_length);
                if (r.payload_length == 8'd0)
                    close_frame();
                else
                begin
                    frame_open = 1'b1;
                    bytes_left = r.payload_length;
                end
            end
        end
        else if (!frame_open)
            n_stray++;
        else
        begin
            emit_frame_byte(r.data_byte);
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0)
                close_frame();
        end
    endfunction

    // Driver: offer the next pending request, hold it until accepted
    always @(posedge clk)
    begin : drive_items
        frame_req_t nxt;
        frame_req_t cur;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                cur.mode           = item_ch.mode;
                cur.opcode         = item_ch.opcode;
                cur.payload_length = item_ch.payload_length;
                cur.capacity       = item_ch.capacity;
                cur.data_byte      = item_ch.data_byte;
                predict_frame(cur);
                n_accepted <= n_accepted + 1;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (pending_reqs.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    nxt = pending_reqs.pop_front();
                    item_ch.valid          <= 1'b1;
                    item_ch.mode           <= nxt.mode;
                    item_ch.opcode         <= nxt.opcode;
                    item_ch.payload_length <= nxt.payload_length;
                    item_ch.capacity       <= nxt.capacity;
                    item_ch.data_byte      <= nxt.data_byte;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare every accepted output byte with the oldest prediction
    always @(posedge clk)
    begin : watch_bytes
        frame_byte_t w;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                n_checked <= n_checked + 1;
                if (want_bytes.size() == 0)
                begin
                    if (n_mismatch < MAX_REPORTS)
                        $display("unexpected byte: out=%02h end=%0b rej=%0b",
                                 res_ch.out_byte, res_ch.frame_end, res_ch.rejected);
                    n_mismatch <= n_mismatch + 1;
                end
                else
                begin
                    w = want_bytes.pop_front();
                    if (res_ch.out_byte !== w.out_byte || res_ch.frame_end !== w.frame_end ||
                        res_ch.rejected !== w.rejected)
                    begin
                        if (n_mismatch < MAX_REPORTS)
                            $display({"byte mismatch: want out=%02h end=%0b rej=%0b, ",
                                      "got out=%02h end=%0b rej=%0b"},
                                     w.out_byte, w.frame_end, w.rejected,
                                     res_ch.out_byte, res_ch.frame_end, res_ch.rejected);
                        n_mismatch <= n_mismatch + 1;
                    end
                end
            end
            res_ch.ready <= !rx_hold && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Long output hold-off so the encoder fills up and stalls its input
    initial
    begin
        rx_hold = 1'b0;
        wait (hold_req === 1'b1);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic push_req(input logic mode, input logic [7:0] opc, input logic [7:0] len,
                            input logic [8:0] cap, input logic [7:0] b);
        frame_req_t r;
        r.mode           = mode;
        r.opcode         = opc;
        r.payload_length = len;
        r.capacity       = cap;
        r.data_byte      = b;
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    task automatic push_start(input logic [7:0] opc, input logic [7:0] len,
                              input logic [8:0] cap);
        push_req(MODE_START, opc, len, cap, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_data(input logic [7:0] b);
        push_req(MODE_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 9'($urandom_range(0, 511)), b);
    endtask

    // Wait for every request to go in and every byte to come out, then settle
    task automatic drain();
        while (n_accepted != n_queued || want_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [cfe_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            cfe_pkg::CFG_MAGIC:   cfg_magic   = val;
            cfe_pkg::CFG_VERSION: cfg_version = val;
            cfe_pkg::CFG_MAX_LEN: cfg_max     = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [7:0] magic, input logic [7:0] ver,
                            input logic [7:0] max_len);
        write_reg(cfe_pkg::CFG_MAGIC, magic);
        write_reg(cfe_pkg::CFG_VERSION, ver);
        write_reg(cfe_pkg::CFG_MAX_LEN, max_len);
        n_settings++;
    endtask

    // Mostly well-formed frames with random content; the rest rejects,
    // frames cut short by a new start, and stray payload bytes
    task automatic queue_random(input int n_target, input int len_hi);
        int queued;
        int pick;
        int len;
        int hi;
        int cut;
        queued = 0;
        while (queued < n_target)
        begin
            pick = $urandom_range(0, 99);
            hi   = (len_hi < int'(cfg_max)) ? len_hi : int'(cfg_max);
            if (pick < 70)
            begin
                if (pick < 3)
                    hi = (int'(cfg_max) < 80) ? int'(cfg_max) : 80;
                len = $urandom_range(0, hi);
                push_start(8'($urandom_range(0, 255)), 8'(len), 9'($urandom_range(len + 6, 511)));
                repeat (len) push_data(8'($urandom_range(0, 255)));
                queued += len + 1;
            end
            else if (pick < 80)
            begin
                len = $urandom_range(0, int'(cfg_max));
                push_start(8'($urandom_range(0, 255)), 8'(len), 9'($urandom_range(0, len + 5)));
                queued++;
            end
            else if (pick < 86 && cfg_max != 8'hFF)
            begin
                len = $urandom_range(int'(cfg_max) + 1, 255);
                push_start(8'($urandom_range(0, 255)), 8'(len), 9'($urandom_range(0, 511)));
                queued++;
            end
            else if (pick < 94 && hi >= 2)
            begin
                len = $urandom_range(2, hi);
                cut = $urandom_range(1, len - 1);
                push_start(8'($urandom_range(0, 255)), 8'(len), 9'($urandom_range(len + 6, 511)));
                repeat (cut) push_data(8'($urandom_range(0, 255)));
                queued += cut + 1;
            end
            else
            begin
                cut = $urandom_range(1, 3);
                repeat (cut) push_data(8'($urandom_range(0, 255)));
                queued += cut;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cycle_cnt   = 0;
        n_queued    = 0;
        n_accepted  = 0;
        n_checked   = 0;
        n_mismatch  = 0;
        n_frames    = 0;
        n_rejects   = 0;
        n_abandoned = 0;
        n_stray     = 0;
        n_settings  = 1;
        no_idle     = 1'b0;
        hold_req    = 1'b0;
        cfg_magic   = cfe_pkg::MAGIC_RST;
        cfg_version = cfe_pkg::VERSION_RST;
        cfg_max     = cfe_pkg::MAX_LEN_RST;
        frame_open  = 1'b0;
        bytes_left  = 8'd0;
        crc_acc     = cfe_pkg::CRC_INIT;

        item_ch.valid          = 1'b0;
        item_ch.mode           = MODE_START;
        item_ch.opcode         = 8'h00;
        item_ch.payload_length = 8'h00;
        item_ch.capacity       = 9'h000;
        item_ch.data_byte      = 8'h00;
        res_ch.ready           = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = cfe_pkg::CFG_MAGIC;
        cfg_ch.data            = 8'h00;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset register values: corner cases
        push_data(8'hFF);                   // stray byte while idle, dropped
        push_start(8'h00, 8'd0, 9'd6);      // empty payload, capacity exactly enough
        push_start(8'hFF, 8'd0, 9'd5);      // one byte short of capacity
        push_start(8'hA5, 8'd3, 9'd9);
        push_data(8'h00);
        push_data(8'hFF);
        push_data(8'h5A);
        push_start(8'h3C, 8'd255, 9'd261);  // longest payload, accepted
        push_data(8'h01);
        push_data(8'hFE);
        push_start(8'h81, 8'd1, 9'd511);    // abandons the open frame
        push_data(8'h80);
        push_start(8'h7E, 8'd255, 9'd260);
        push_start(8'h18, 8'd250, 9'd0);
        drain();

        // All-ones header, only empty payloads allowed
        set_regs(8'hFF, 8'hFF, 8'h00);
        no_idle <= 1'b1;
        push_start(8'h55, 8'd0, 9'd6);
        push_start(8'hAA, 8'd1, 9'd511);
        push_data(8'h33);
        push_start(8'hFF, 8'd255, 9'd511);
        push_start(8'h00, 8'd0, 9'd511);
        drain();
        no_idle <= 1'b0;

        set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'hFF);
        queue_random(95, 12);
        hold_req <= 1'b1;
        drain();

        set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(4, 20)));
        queue_random(85, 24);
        drain();

        set_regs(8'h00, 8'h00, 8'hFF);
        no_idle <= 1'b1;
        queue_random(40, 10);
        drain();

        $display("covered %0d frames, %0d rejects, %0d abandoned frames, %0d dropped stray bytes",
                 n_frames, n_rejects, n_abandoned, n_stray);
        $display("%0d requests in, %0d bytes checked over %0d register settings, %0d mismatches",
                 n_accepted, n_checked, n_settings, n_mismatch);
        if (n_mismatch == 0 && want_bytes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
